// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define CED_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CED_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ced_pkg.sv
// types, constants and helper functions of the escape decoder
`default_nettype none
package ced_pkg;

  localparam int COUNT_BITS = 16;
  localparam int SHOWN_W    = 16;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_OCT    = 3'd2;
  localparam logic [2:0] MODE_HEX0   = 3'd3;
  localparam logic [2:0] MODE_HEX1   = 3'd4;
  localparam logic [2:0] MODE_SKIP   = 3'd5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [3:0] HEX_MASK = 4'hf;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               end_of_string;
    logic [SHOWN_W-1:0] decoded_count;
  } out_t;

  // results of one decode step, in order
  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } step_t;

  // output buffer status seen by the top level
  typedef struct packed {
    logic room;
    logic tail_v;
  } outq_stat_t;

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_7);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // letters get 9 added so the low nibble lands on 10..15
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] x;
    x = (c > CH_9) ? (c + 8'd9) : c;
    return x[3:0] & HEX_MASK;
  endfunction

  // simple one-character escapes: {hit, value}
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    case (c)
      8'h61:   return {1'b1, 8'h07};
      8'h62:   return {1'b1, 8'h08};
      8'h66:   return {1'b1, 8'h0c};
      8'h6e:   return {1'b1, 8'h0a};
      8'h72:   return {1'b1, 8'h0d};
      8'h74:   return {1'b1, 8'h09};
      8'h76:   return {1'b1, 8'h0b};
      8'h5c:   return {1'b1, c};
      8'h3f:   return {1'b1, c};
      8'h27:   return {1'b1, c};
      8'h22:   return {1'b1, c};
      default: return {1'b0, 8'h00};
    endcase
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] t);
    return (t == {COUNT_BITS{1'b1}}) ? t : (t + COUNT_BITS'(1));
  endfunction

  function automatic logic [SHOWN_W-1:0] shown(input logic [COUNT_BITS-1:0] t);
    return (32'(t) > 32'h0000_ffff) ? {SHOWN_W{1'b1}} : SHOWN_W'(t);
  endfunction

endpackage
`default_nettype wire

// File: rtl/ced_core.sv
// decode state registers and the single-pass decode logic
`default_nettype none
module ced_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire ced_pkg::in_t  item,
  output ced_pkg::step_t     step
);

  logic [2:0]                     mode_r, mode_nxt;
  logic [7:0]                     pend_r, pend_nxt;
  logic [1:0]                     dig_r, dig_nxt;
  logic [ced_pkg::COUNT_BITS-1:0] total_r, total_nxt;

  always_comb begin
    logic [7:0]                     b;
    logic                           c1_v, c2_v, c3_v;
    logic [7:0]                     c1_b, c2_b, c3_b;
    logic                           ended, do_plain, skip, fin;
    logic [8:0]                     esc;
    logic [7:0]                     oct_acc;
    logic [1:0]                     dig_inc;
    logic [ced_pkg::COUNT_BITS-1:0] t1, t2;
    logic [1:0]                     n;
    logic [7:0]                     r0_b, r1_b;

    b        = item.in_byte;
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    dig_nxt  = dig_r;
    c1_v = 1'b0; c1_b = '0;
    c2_v = 1'b0; c2_b = '0;
    c3_v = 1'b0; c3_b = '0;
    ended    = 1'b0;
    do_plain = 1'b0;
    skip     = 1'b0;
    esc      = ced_pkg::esc_map(b);
    oct_acc  = {pend_r[4:0], b[2:0]};
    dig_inc  = dig_r + 2'd1;

    case (mode_r)
      ced_pkg::MODE_SKIP: begin
        skip = 1'b1;
      end
      ced_pkg::MODE_ESC: begin
        mode_nxt = ced_pkg::MODE_NORMAL;
        if (b == ced_pkg::CH_NUL) begin
          ended = 1'b1;
        end else if (esc[8]) begin
          c1_v = 1'b1;
          c1_b = esc[7:0];
        end else if ((b == ced_pkg::CH_X_LO) || (b == ced_pkg::CH_X_UP)) begin
          mode_nxt = ced_pkg::MODE_HEX0;
        end else if (ced_pkg::is_oct(b)) begin
          pend_nxt = {5'd0, b[2:0]};
          dig_nxt  = 2'd1;
          mode_nxt = ced_pkg::MODE_OCT;
        end
      end
      ced_pkg::MODE_OCT: begin
        if (ced_pkg::is_oct(b)) begin
          if (dig_inc == 2'd3) begin
            c1_v     = 1'b1;
            c1_b     = oct_acc;
            mode_nxt = ced_pkg::MODE_NORMAL;
            pend_nxt = '0;
            dig_nxt  = '0;
          end else begin
            pend_nxt = oct_acc;
            dig_nxt  = dig_inc;
          end
        end else begin
          c1_v     = 1'b1;
          c1_b     = pend_r;
          do_plain = 1'b1;
        end
      end
      ced_pkg::MODE_HEX0: begin
        if (ced_pkg::is_hex(b)) begin
          pend_nxt = {4'd0, ced_pkg::hex_val(b)};
          mode_nxt = ced_pkg::MODE_HEX1;
        end else begin
          do_plain = 1'b1;
        end
      end
      ced_pkg::MODE_HEX1: begin
        if (ced_pkg::is_hex(b)) begin
          c1_v     = 1'b1;
          c1_b     = {pend_r[3:0], ced_pkg::hex_val(b)};
          mode_nxt = ced_pkg::MODE_NORMAL;
          pend_nxt = '0;
        end else begin
          c1_v     = 1'b1;
          c1_b     = pend_r;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      mode_nxt = ced_pkg::MODE_NORMAL;
      pend_nxt = '0;
      dig_nxt  = '0;
      if (b == ced_pkg::CH_NUL) begin
        ended = 1'b1;
      end else if (b == ced_pkg::CH_BSL) begin
        mode_nxt = ced_pkg::MODE_ESC;
      end else begin
        c2_v = 1'b1;
        c2_b = b;
      end
    end

    fin = !skip && (ended || item.last);

    // flush a pending number at the end of the string
    if (!skip && !ended && item.last &&
        ((mode_nxt == ced_pkg::MODE_OCT) || (mode_nxt == ced_pkg::MODE_HEX1))) begin
      c3_v = 1'b1;
      c3_b = pend_nxt;
    end

    // pack the emitted bytes in order
    n    = 2'(c1_v) + 2'(c2_v) + 2'(c3_v);
    r0_b = c1_v ? c1_b : (c2_v ? c2_b : c3_b);
    r1_b = (c1_v && c2_v) ? c2_b : c3_b;

    t1 = ced_pkg::sat_inc(total_r);
    t2 = ced_pkg::sat_inc(t1);

    step.r0.out_byte      = r0_b;
    step.r0.byte_valid    = 1'b1;
    step.r0.end_of_string = 1'b0;
    step.r0.decoded_count = ced_pkg::shown(t1);
    step.r1.out_byte      = r1_b;
    step.r1.byte_valid    = 1'b1;
    step.r1.end_of_string = 1'b0;
    step.r1.decoded_count = ced_pkg::shown(t2);
    step.n                = n;

    total_nxt = (n == 2'd0) ? total_r : ((n == 2'd1) ? t1 : t2);

    if (fin) begin
      if (n == 2'd0) begin
        step.r0.out_byte      = '0;
        step.r0.byte_valid    = 1'b0;
        step.r0.end_of_string = 1'b1;
        step.r0.decoded_count = ced_pkg::shown(total_r);
        step.n                = 2'd1;
      end else if (n == 2'd1) begin
        step.r0.end_of_string = 1'b1;
      end else begin
        step.r1.end_of_string = 1'b1;
      end
      mode_nxt  = (ended && !item.last) ? ced_pkg::MODE_SKIP : ced_pkg::MODE_NORMAL;
      pend_nxt  = '0;
      dig_nxt   = '0;
      total_nxt = '0;
    end else if (skip && item.last) begin
      mode_nxt  = ced_pkg::MODE_NORMAL;
      pend_nxt  = '0;
      dig_nxt   = '0;
      total_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ced_pkg::MODE_NORMAL;
      pend_r  <= '0;
      dig_r   <= '0;
      total_r <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      dig_r   <= dig_nxt;
      total_r <= total_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ced_outq.sv
// two-entry result buffer between the decoder and the output channel
`default_nettype none
module ced_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire ced_pkg::step_t  step,
  input  wire logic            out_stall,
  output logic                 out_valid,
  output ced_pkg::out_t        out_data,
  output ced_pkg::outq_stat_t  stat
);

  logic          head_v_r, head_v_nxt;
  logic          tail_v_r, tail_v_nxt;
  ced_pkg::out_t head_r, head_nxt;
  ced_pkg::out_t tail_r, tail_nxt;
  logic          pop;

  assign pop         = head_v_r && !out_stall;
  assign stat.room   = !tail_v_r && (!head_v_r || pop);
  assign stat.tail_v = tail_v_r;
  assign out_valid   = head_v_r;
  assign out_data    = head_r;

  always_comb begin
    head_v_nxt = head_v_r;
    tail_v_nxt = tail_v_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    if (push) begin
      // push only comes with room, so both slots are free after the pop
      head_v_nxt = (step.n != 2'd0);
      tail_v_nxt = (step.n == 2'd2);
      head_nxt   = step.r0;
      tail_nxt   = step.r1;
    end else if (pop) begin
      head_v_nxt = tail_v_r;
      tail_v_nxt = 1'b0;
      head_nxt   = tail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      tail_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      tail_v_r <= tail_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/c_escape_decoder.sv
// top level of the streaming c escape-sequence decoder
`default_nettype none
// Streaming C escape decoder: one source byte per word in, decoded bytes out.
// Plain bytes pass through, backslash escapes (control letters, quote marks,
// backslash, question mark, one to three octal digits, x with one or two hex
// digits) become one byte, unknown escapes and a dangling backslash are dropped.
// A zero byte ends the string and later bytes are swallowed up to the one flagged
// last; the final word of each string carries end_of_string and the saturating
// byte count. Timing: a byte is registered on entry, decoded in one pass and
// written to a two-entry result buffer, so one word is taken every cycle while
// the buffer has room. A word that yields two results (a pending octal or hex
// value flushed by the next byte) fills both buffer entries and holds off the
// next input word. Words go through the input register, then the head entry.
`include "assert_macros.svh"
module c_escape_decoder (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ced_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ced_pkg::out_t      out_data
);

  // input register
  logic                in_v_r;
  ced_pkg::in_t        in_r;
  logic                fire;
  logic                room;
  ced_pkg::step_t      step;
  ced_pkg::outq_stat_t stat;

  assign room     = stat.room;
  // decode the held word once the buffer can take up to two results
  assign fire     = in_v_r && room;
  assign in_stall = in_v_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  ced_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_r),
    .step  (step)
  );

  ced_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .step      (step),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

  // second buffer entry is only ever filled behind the first
  `CED_ASSERT_IMP(a_tail_behind_head, stat.tail_v, out_valid, "tail entry without head")
  // a two-result word blocks the decoder for the next cycle
  `CED_ASSERT_NXT(a_two_hold, fire && (step.n == 2'd2), !room, "buffer room after two")
  // a last-flagged word that yields anything closes the string on its final result
  // (the last word of a swallowed tail yields nothing)
  `CED_ASSERT_IMP(a_last_closes, fire && in_r.last && (step.n != 2'd0),
    ((step.n == 2'd1) && step.r0.end_of_string) ||
    ((step.n == 2'd2) && step.r1.end_of_string && !step.r0.end_of_string),
    "last word without end marker")
  // a word with no byte is a bare end marker with a zero byte
  `CED_ASSERT_IMP(a_bare_marker, out_valid && !out_data.byte_valid,
    out_data.end_of_string && (out_data.out_byte == 8'h00), "malformed end marker")

endmodule
`default_nettype wire

// File: sim/c_escape_decoder_tb.sv
// self-checking testbench for the streaming c escape-sequence decoder
`timescale 1ns / 1ps
module c_escape_decoder_tb;
  import ced_pkg::*;

  localparam int IDLE_LIMIT    = 5000;   // cycles with no word moving on either side
  localparam int SETTLE_CYCLES = 16;     // well past the decoder's latency
  localparam int MAX_REPORTS   = 10;

  // characters the random strings are built from
  localparam string ESC_CHARS   = "abfnrtv\\?'\"";
  localparam string HEX_CHARS   = "0123456789abcdefABCDEF";
  localparam string PROBE_CHARS = "0123456789abcdefgABCDEFGxXz\\?";

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  in_t   in_data   = '0;
  logic  out_stall = 1'b0;
  logic  in_stall;
  logic  out_valid;
  out_t  out_data;

  c_escape_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // decoder state as the scoreboard sees it
  logic [2:0]            dec_mode   = MODE_NORMAL;
  logic [7:0]            dec_value  = '0;
  logic [1:0]            dec_digits = '0;
  logic [COUNT_BITS-1:0] dec_total  = '0;

  out_t       step_words[$];   // results of the byte being decoded
  out_t       decoded_q[$];    // decoded words still owed by the block
  logic [7:0] txt[$];          // source string about to be sent

  int fault_count = 0;
  int items_sent  = 0;
  int gap_max     = 0;         // 0: sender never idles
  int burst_left  = 0;
  int stall_pct   = 0;         // 0: receiver never stalls
  int stall_run   = 0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  task automatic reset_decoder();
    dec_mode   = MODE_NORMAL;
    dec_value  = '0;
    dec_digits = '0;
    dec_total  = '0;
  endtask

  function automatic logic [SHOWN_W-1:0] visible_count();
    return (32'(dec_total) > 32'h0000_ffff) ? {SHOWN_W{1'b1}} : SHOWN_W'(dec_total);
  endfunction

  // one decoded byte, count saturates at the top of the counter
  task automatic push_byte(input logic [7:0] b);
    out_t t;
    if (dec_total != {COUNT_BITS{1'b1}})
      dec_total = dec_total + 1'b1;
    t.out_byte      = b;
    t.byte_valid    = 1'b1;
    t.end_of_string = 1'b0;
    t.decoded_count = visible_count();
    step_words.insert(step_words.size(), t);
  endtask

  // byte seen outside any escape; flags a terminating zero
  task automatic take_plain(input logic [7:0] b, output logic ended);
    dec_mode   = MODE_NORMAL;
    dec_value  = '0;
    dec_digits = '0;
    ended      = 1'b0;
    if (b == CH_NUL)
      ended = 1'b1;
    else if (b == CH_BSL)
      dec_mode = MODE_ESC;
    else
      push_byte(b);
  endtask

  task automatic decode_byte(input in_t w);
    logic [7:0] b;
    logic       ended;
    logic       hex_ok;
    logic [3:0] hex_nib;
    out_t       t;
    b       = w.in_byte;
    ended   = 1'b0;
    hex_ok  = (b >= CH_0 && b <= CH_9) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    hex_nib = (b > CH_9) ? b[3:0] + 4'd9 : b[3:0];
    step_words.delete();
    if (dec_mode == MODE_SKIP) begin
      // swallowing the tail after a zero, nothing comes out
      if (w.last)
        reset_decoder();
    end else begin
      case (dec_mode)
        MODE_ESC: begin
          dec_mode = MODE_NORMAL;
          case (b)
            CH_NUL:             ended = 1'b1;
            "a":                push_byte(8'h07);
            "b":                push_byte(8'h08);
            "f":                push_byte(8'h0c);
            "n":                push_byte(8'h0a);
            "r":                push_byte(8'h0d);
            "t":                push_byte(8'h09);
            "v":                push_byte(8'h0b);
            "\\", "?", "'", "\"": push_byte(b);
            CH_X_LO, CH_X_UP:   dec_mode = MODE_HEX0;
            default: begin
              // octal opens a value, anything else is dropped with its backslash
              if (b >= CH_0 && b <= CH_7) begin
                dec_value  = {5'd0, b[2:0]};
                dec_digits = 2'd1;
                dec_mode   = MODE_OCT;
              end
            end
          endcase
        end
        MODE_OCT: begin
          if (b >= CH_0 && b <= CH_7) begin
            dec_value  = {dec_value[4:0], b[2:0]};
            dec_digits = dec_digits + 2'd1;
            if (dec_digits == 2'd3) begin
              push_byte(dec_value);
              dec_mode   = MODE_NORMAL;
              dec_value  = '0;
              dec_digits = '0;
            end
          end else begin
            push_byte(dec_value);
            take_plain(b, ended);
          end
        end
        MODE_HEX0: begin
          if (hex_ok) begin
            dec_value = {4'd0, hex_nib};
            dec_mode  = MODE_HEX1;
          end else begin
            take_plain(b, ended);
          end
        end
        MODE_HEX1: begin
          if (hex_ok) begin
            push_byte({dec_value[3:0], hex_nib});
            dec_mode  = MODE_NORMAL;
            dec_value = '0;
          end else begin
            push_byte(dec_value);
            take_plain(b, ended);
          end
        end
        default: take_plain(b, ended);
      endcase

      if (ended || w.last) begin
        // end without a zero flushes a pending numeric value
        if (!ended && (dec_mode == MODE_OCT || dec_mode == MODE_HEX1))
          push_byte(dec_value);
        // end marker rides on the last data word, or stands alone
        if (step_words.size() > 0) begin
          t = step_words.pop_back();
          t.end_of_string = 1'b1;
        end else begin
          t.out_byte      = 8'h00;
          t.byte_valid    = 1'b0;
          t.end_of_string = 1'b1;
          t.decoded_count = visible_count();
        end
        step_words.insert(step_words.size(), t);
        reset_decoder();
        if (ended && !w.last)
          dec_mode = MODE_SKIP;
      end
      foreach (step_words[i])
        decoded_q.insert(decoded_q.size(), step_words[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // scoreboard: check result words, then predict from accepted source words
  // ---------------------------------------------------------------------------

  task automatic note_fault(input string what, input logic [31:0] want, input logic [31:0] got);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : score
    out_t exp_w;
    if (rst_n) begin
      if (out_valid && out_stall === 1'b0) begin
        if (decoded_q.size() == 0) begin
          note_fault("result word with nothing pending, out_byte", '0, out_data.out_byte);
        end else begin
          exp_w = decoded_q.pop_front();
          if (out_data.out_byte !== exp_w.out_byte)
            note_fault("out_byte", exp_w.out_byte, out_data.out_byte);
          if (out_data.byte_valid !== exp_w.byte_valid)
            note_fault("byte_valid", exp_w.byte_valid, out_data.byte_valid);
          if (out_data.end_of_string !== exp_w.end_of_string)
            note_fault("end_of_string", exp_w.end_of_string, out_data.end_of_string);
          if (out_data.decoded_count !== exp_w.decoded_count)
            note_fault("decoded_count", exp_w.decoded_count, out_data.decoded_count);
        end
      end
      if (in_valid && in_stall === 1'b0)
        decode_byte(in_data);
    end
  end

  // receiver stalls in runs of random length, density set per phase
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_run = $urandom_range(1, 8);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end else begin
      stall_run--;
    end
  end

  // watchdog: too long with no word moving on either side
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid && out_stall === 1'b0))
        idle = 0;
      else
        idle++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // one source word; with gap_max set, sender idles between bursts once the word is taken
  task automatic send_word(input in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
    items_sent++;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // sends the queued string, last flagged on its final byte
  task automatic send_txt();
    in_t w;
    foreach (txt[i]) begin
      w = {txt[i], i == txt.size() - 1};
      send_word(w);
    end
  endtask

  // appends one byte to the source string
  task automatic add_txt(input logic [7:0] b);
    txt.insert(txt.size(), b);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++)
      add_txt(s[i]);
  endtask

  // sender holds off until every decoded word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    return (b == CH_BSL) ? 8'h41 : b;
  endfunction

  // random mix of plain text and escapes, ended by last or by a zero
  task automatic build_escaped_string();
    int n_tok;
    n_tok = $urandom_range(0, 8);
    repeat (n_tok) begin
      case ($urandom_range(0, 10))
        0, 1: add_txt(plain_byte());
        2: begin
          add_txt(CH_BSL);
          add_txt(ESC_CHARS[$urandom_range(0, ESC_CHARS.len() - 1)]);
        end
        3, 4: begin
          add_txt(CH_BSL);
          repeat ($urandom_range(1, 3)) add_txt(CH_0 + 8'($urandom_range(0, 7)));
        end
        5, 6: begin
          add_txt(CH_BSL);
          add_txt($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
          repeat ($urandom_range(1, 2))
            add_txt(HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)]);
        end
        7: begin
          // x with no digit of its own, whatever follows decides
          add_txt(CH_BSL);
          add_txt($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
        end
        8: begin
          add_txt(CH_BSL);
          add_txt(8'($urandom_range(1, 255)));
        end
        9: add_txt(PROBE_CHARS[$urandom_range(0, PROBE_CHARS.len() - 1)]);
        default: add_txt(CH_BSL);
      endcase
    end
    if (n_tok == 0 || $urandom_range(0, 3) == 0) begin
      add_txt(CH_NUL);
      repeat ($urandom_range(0, 3)) add_txt(8'($urandom_range(0, 255)));
    end
  endtask

  // unstructured bytes, biased toward the characters the decoder cares about
  task automatic build_noise_string();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 15))
        0:          add_txt(CH_NUL);
        1, 2, 3, 4: add_txt(PROBE_CHARS[$urandom_range(0, PROBE_CHARS.len() - 1)]);
        default:    add_txt(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic test_directed_cases();
    gap_max   = 0;
    stall_pct = 0;
    // three octal digits wrap to a byte, marker merged on that word
    txt.delete(); append_text("\\777"); send_txt();
    // two octal digits and one hex digit flushed by the next byte, bare x at end
    txt.delete(); append_text("\\12A\\xfG\\x"); send_txt();
    // unknown escape, zero with a bare x pending, tail swallowed
    txt.delete(); append_text("\\q\\X"); add_txt(CH_NUL); append_text("ab"); send_txt();
    // all-ones byte passes, trailing lone backslash dropped
    txt.delete(); add_txt(8'hff); append_text("\\"); send_txt();
    // empty string: zero alone
    txt.delete(); add_txt(CH_NUL); send_txt();
    // zero while an octal value is pending
    txt.delete(); append_text("\\5"); add_txt(CH_NUL); send_txt();
    // end with one hex digit pending, uppercase x
    txt.delete(); append_text("\\X3"); send_txt();
    // zero right after a backslash, backslash in the swallowed tail
    txt.delete(); append_text("\\"); add_txt(CH_NUL); append_text("\\"); send_txt();
    // control letters and quote escapes
    txt.delete(); append_text("\\a\\v\\\""); send_txt();
    wait_drained();
  endtask

  task automatic test_wellformed_streams(input int n_items, input int gap_lim,
                                         input int stall_lim);
    int start;
    gap_max   = gap_lim;
    stall_pct = stall_lim;
    start     = items_sent;
    while (items_sent - start < n_items) begin
      txt.delete();
      if ($urandom_range(0, 9) == 0)
        build_noise_string();
      else
        build_escaped_string();
      send_txt();
    end
    wait_drained();
  endtask

  task automatic test_garbage_streams(input int n_items, input int gap_lim,
                                      input int stall_lim);
    int start;
    gap_max   = gap_lim;
    stall_pct = stall_lim;
    start     = items_sent;
    while (items_sent - start < n_items) begin
      txt.delete();
      build_noise_string();
      send_txt();
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_wellformed_streams(400, 0, 0);
    test_wellformed_streams(500, 6, 40);
    test_garbage_streams(350, 3, 65);
    wait_drained();
    if (fault_count == 0 && decoded_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ced_pkg.sv
rtl/ced_core.sv
rtl/ced_outq.sv
rtl/c_escape_decoder.sv
sim/c_escape_decoder_tb.sv
